FILE: rtl/core/rhhs_pkg.sv
// Shared types and constants for the Robin Hood hash set core.
// Holds the default sizes, operation and status codes, and the channel words.
// No dependencies.
`default_nettype none
package rhhs_pkg;

  localparam int TABLE_CAPACITY = 64;
  localparam int MAX_PROBE      = 6;
  localparam int KEY_WIDTH      = 32;
  localparam int VALUE_WIDTH    = 32;
  localparam int HASH_DIGIT     = 16;

  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_REMOVE,
    MODE_LOOKUP,
    MODE_CLEAR
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DUPLICATE,
    ST_NOT_FOUND,
    ST_FULL
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] key_hash;
    logic [31:0] entry_value;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic        found;
    logic [31:0] result_value;
    logic [6:0]  entry_count;
  } out_word_t;

endpackage
`default_nettype wire

FILE: rtl/core/rhhs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module rhhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/robin_hood_hash_set_core.sv
// Robin Hood hash set with backward-shift removal, held in one slot RAM.
// Depends on rhhs_pkg and rhhs_ram.
//
// One word is worked on at a time. The home slot is reduced from the key in
// 16-bit digits by a reciprocal multiplication and one correcting
// subtraction, each digit passing through S_HASH and S_HASH_RED; then every
// slot visited is read and then evaluated on the single RAM read port. An
// insert walks from its stop slot to the empty slot twice (one scan pass and
// one write pass), a remove shifts the following entries of its run back by
// one slot, and a clear touches no slot because occupancy lives in per-slot
// flip-flops. A finished result waits in the output register while the next
// word is accepted; a stalled output holds the core until that register is
// free.
`default_nettype none
module robin_hood_hash_set_core #(
  parameter int TABLE_CAPACITY = rhhs_pkg::TABLE_CAPACITY,
  parameter int MAX_PROBE      = rhhs_pkg::MAX_PROBE,
  parameter int KEY_WIDTH      = rhhs_pkg::KEY_WIDTH,
  parameter int VALUE_WIDTH    = rhhs_pkg::VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rhhs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rhhs_pkg::out_word_t out_data
);
  import rhhs_pkg::*;

  localparam int SLOT_COUNT = TABLE_CAPACITY + MAX_PROBE;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int DW         = $clog2(MAX_PROBE + 1);
  localparam int SLOT_W     = DW + KEY_WIDTH + VALUE_WIDTH;
  localparam int CW         = $clog2(SLOT_COUNT + 1);
  localparam int CB         = $clog2(TABLE_CAPACITY);
  localparam int XW         = CB + HASH_DIGIT;
  localparam int PW         = XW + 1 + HASH_DIGIT;
  localparam logic [XW:0] RECIP =
    (XW + 1)'((64'd1 << (XW + 1)) / 64'(TABLE_CAPACITY));
  localparam int HASH_STEPS = (KEY_WIDTH + HASH_DIGIT - 1) / HASH_DIGIT;
  localparam int PADW       = HASH_STEPS * HASH_DIGIT;
  localparam int HW         = $clog2(HASH_STEPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HASH, S_HASH_RED, S_LK_RD, S_LK_EV, S_SC_RD, S_SC_EV,
    S_WR_RD, S_WR_EV, S_RM_RD, S_RM_EV, S_DONE
  } state_t;

  state_t                  state_r;
  mode_t                   mode_r;
  logic [KEY_WIDTH-1:0]    key_r;
  logic [VALUE_WIDTH-1:0]  val_r;
  logic [PADW-1:0]         kshift_r;
  logic [CB-1:0]           rem_r;
  logic [CB-1:0]           rem_nxt;
  logic [XW-1:0]           hx_r;
  logic [PW-1:0]           hprod_r;
  logic [XW-1:0]           hx_v;
  logic [XW-1:0]           hqc_v;
  logic [XW-1:0]           hr_v;
  logic [HW-1:0]           hs_r;
  logic [SLOT_AW-1:0]      idx_r;
  logic [SLOT_AW-1:0]      pos_r;
  logic [SLOT_AW-1:0]      j_r;
  logic [SLOT_AW-1:0]      nidx;
  logic [DW-1:0]           d_r;
  logic [SLOT_W-1:0]       carry_r;
  logic [SLOT_COUNT-1:0]   valid_r;
  logic [CW-1:0]           cnt_r;
  status_t                 status_r;
  logic                    found_r;
  logic [VALUE_WIDTH-1:0]  rval_r;
  logic                    out_valid_r;
  out_word_t               out_r;

  logic                    ram_we;
  logic [SLOT_AW-1:0]      ram_waddr;
  logic [SLOT_W-1:0]       ram_wdata;
  logic [SLOT_AW-1:0]      ram_raddr;
  logic [SLOT_W-1:0]       ram_rdata;

  logic [63:0]             key_ext;
  logic [63:0]             val_ext;
  logic [63:0]             rval_ext;
  logic [63:0]             cnt_ext;
  logic [DW-1:0]           rd_dist;
  logic [KEY_WIDTH-1:0]    rd_key;
  logic [VALUE_WIDTH-1:0]  rd_val;
  logic                    occ;
  logic                    lk_hit;
  logic                    lk_stop;
  logic                    rm_move;
  logic [DW:0]             dist_inc;
  logic [CW-1:0]           cnt_dec;

  rhhs_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign key_ext  = {32'd0, in_data.key_hash};
  assign val_ext  = {32'd0, in_data.entry_value};
  assign rval_ext = 64'(rval_r);
  assign cnt_ext  = 64'(cnt_r);

  assign rd_dist  = ram_rdata[SLOT_W-1 -: DW];
  assign rd_key   = ram_rdata[VALUE_WIDTH +: KEY_WIDTH];
  assign rd_val   = ram_rdata[VALUE_WIDTH-1:0];
  assign nidx     = idx_r + 1'b1;
  assign occ      = valid_r[idx_r];
  assign lk_hit   = occ && (rd_key == key_r);
  assign lk_stop  = !occ || (rd_dist < d_r) || (rd_key == key_r);
  assign rm_move  = valid_r[nidx] && (rd_dist != '0);
  assign dist_inc = {1'b0, rd_dist} + 1'b1;
  assign cnt_dec  = (cnt_r != '0) ? cnt_r - 1'b1 : cnt_r;

  always_comb begin
    hx_v  = {rem_r, kshift_r[PADW-1 -: HASH_DIGIT]};
    hqc_v = XW'(hprod_r[PW-1 -: HASH_DIGIT]) * XW'(TABLE_CAPACITY);
    hr_v  = hx_r - hqc_v;
    if (hr_v >= XW'(TABLE_CAPACITY)) begin
      hr_v = hr_v - XW'(TABLE_CAPACITY);
    end
    rem_nxt = CB'(hr_v);
  end

  always_comb begin
    ram_raddr = idx_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = carry_r;
    case (state_r)
      S_RM_RD: begin
        ram_raddr = nidx;
      end
      S_WR_EV: begin
        ram_we = 1'b1;
      end
      S_RM_EV: begin
        ram_we    = rm_move;
        ram_wdata = {rd_dist - 1'b1, rd_key, rd_val};
      end
      default: begin
        ram_raddr = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r   <= in_data.mode;
            key_r    <= key_ext[KEY_WIDTH-1:0];
            val_r    <= val_ext[VALUE_WIDTH-1:0];
            kshift_r <= PADW'(key_ext[KEY_WIDTH-1:0]);
            rem_r    <= '0;
            hs_r     <= '0;
            status_r <= ST_OK;
            found_r  <= 1'b0;
            rval_r   <= '0;
            if (in_data.mode == MODE_CLEAR) begin
              valid_r <= '0;
              cnt_r   <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_HASH;
            end
          end
        end
        S_HASH: begin
          hx_r     <= hx_v;
          hprod_r  <= PW'(hx_v) * PW'(RECIP);
          kshift_r <= kshift_r << HASH_DIGIT;
          state_r  <= S_HASH_RED;
        end
        S_HASH_RED: begin
          rem_r <= rem_nxt;
          hs_r  <= hs_r + 1'b1;
          if (hs_r == HW'(HASH_STEPS - 1)) begin
            idx_r   <= SLOT_AW'(rem_nxt);
            d_r     <= '0;
            state_r <= S_LK_RD;
          end else begin
            state_r <= S_HASH;
          end
        end
        S_LK_RD: begin
          state_r <= S_LK_EV;
        end
        S_LK_EV: begin
          if (lk_stop) begin
            pos_r <= idx_r;
            case (mode_r)
              MODE_INSERT: begin
                if (lk_hit) begin
                  status_r <= ST_DUPLICATE;
                  found_r  <= 1'b1;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_SC_RD;
                end
              end
              MODE_REMOVE: begin
                if (lk_hit) begin
                  found_r <= 1'b1;
                  rval_r  <= rd_val;
                  state_r <= S_RM_RD;
                end else begin
                  status_r <= ST_NOT_FOUND;
                  state_r  <= S_DONE;
                end
              end
              default: begin
                if (lk_hit) begin
                  found_r <= 1'b1;
                  rval_r  <= rd_val;
                end else begin
                  status_r <= ST_NOT_FOUND;
                end
                state_r <= S_DONE;
              end
            endcase
          end else if (d_r == DW'(MAX_PROBE - 1)) begin
            status_r <= (mode_r == MODE_INSERT) ? ST_FULL : ST_NOT_FOUND;
            state_r  <= S_DONE;
          end else begin
            d_r     <= d_r + 1'b1;
            idx_r   <= nidx;
            state_r <= S_LK_RD;
          end
        end
        S_SC_RD: begin
          state_r <= S_SC_EV;
        end
        S_SC_EV: begin
          if (!occ) begin
            j_r     <= idx_r;
            idx_r   <= pos_r;
            carry_r <= {d_r, key_r, val_r};
            state_r <= S_WR_RD;
          end else if (dist_inc >= (DW + 1)'(MAX_PROBE) ||
                       idx_r == SLOT_AW'(SLOT_COUNT - 1)) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else begin
            idx_r   <= nidx;
            state_r <= S_SC_RD;
          end
        end
        S_WR_RD: begin
          state_r <= S_WR_EV;
        end
        S_WR_EV: begin
          valid_r[idx_r] <= 1'b1;
          if (idx_r == j_r) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_DONE;
          end else begin
            carry_r <= {dist_inc[DW-1:0], rd_key, rd_val};
            idx_r   <= nidx;
            state_r <= S_WR_RD;
          end
        end
        S_RM_RD: begin
          if (idx_r == SLOT_AW'(SLOT_COUNT - 1)) begin
            valid_r[idx_r] <= 1'b0;
            cnt_r          <= cnt_dec;
            state_r        <= S_DONE;
          end else begin
            state_r <= S_RM_EV;
          end
        end
        S_RM_EV: begin
          if (rm_move) begin
            idx_r   <= nidx;
            state_r <= S_RM_RD;
          end else begin
            valid_r[idx_r] <= 1'b0;
            cnt_r          <= cnt_dec;
            state_r        <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_r.status       <= status_r;
            out_r.found        <= found_r;
            out_r.result_value <= rval_ext[31:0];
            out_r.entry_count  <= cnt_ext[6:0];
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (CW'($countones(valid_r)) == cnt_r))
    else $error("entry count differs from occupied slots");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_WR_EV || state_r == S_RM_EV))
    else $error("slot write outside a shift pass");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LK_EV) |-> (d_r < DW'(MAX_PROBE)))
    else $error("probe distance reached the maximum during search");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR_EV) |-> (idx_r <= j_r))
    else $error("insert shift ran past its empty slot");

endmodule
`default_nettype wire

FILE: tb/sv/tb_robin_hood_hash_set_core.sv
// Testbench for robin_hood_hash_set_core: random and directed set operations
// checked word by word against an internal model of the hash set.
// Depends on rhhs_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_robin_hood_hash_set_core;
  import rhhs_pkg::*;

  localparam int SLOTS = TABLE_CAPACITY + MAX_PROBE;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  in_word_t pending_ops[$];
  out_word_t expected_answers[$];
  int errors = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit timed_out = 0;

  int unsigned set_dist[SLOTS];
  logic [31:0] set_key[SLOTS];
  logic [31:0] set_val[SLOTS];
  int unsigned set_count;

  logic [31:0] live_keys[$];

  robin_hood_hash_set_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic void clear_set();
    for (int i = 0; i < SLOTS; i++) begin
      set_dist[i] = MAX_PROBE;
      set_key[i] = '0;
      set_val[i] = '0;
    end
    set_count = 0;
  endfunction

  function automatic bit probe_walk(logic [31:0] key, output int pos, output int walk_d);
    int idx;
    int d;
    idx = key % TABLE_CAPACITY;
    d = 0;
    while (d < MAX_PROBE) begin
      if (set_dist[idx] < d || set_dist[idx] >= MAX_PROBE || set_key[idx] == key) break;
      d++;
      idx++;
    end
    pos = idx;
    walk_d = d;
    return d < MAX_PROBE;
  endfunction

  function automatic out_word_t apply_op(in_word_t w);
    out_word_t r;
    int pos;
    int home_d;
    int j;
    int i;
    bit ok;
    bit hit;
    r = '0;
    r.status = ST_OK;
    case (w.mode)
      MODE_INSERT: begin
        if (!probe_walk(w.key_hash, pos, home_d)) begin
          r.status = ST_FULL;
        end else if (set_dist[pos] < MAX_PROBE && set_key[pos] == w.key_hash) begin
          r.status = ST_DUPLICATE;
          r.found = 1'b1;
        end else begin
          ok = 0;
          for (j = pos; j < SLOTS; j++) begin
            if (set_dist[j] >= MAX_PROBE) begin
              ok = 1;
              break;
            end
            if (set_dist[j] + 1 >= MAX_PROBE) break;
          end
          if (!ok) begin
            r.status = ST_FULL;
          end else begin
            for (i = j; i > pos; i--) begin
              set_dist[i] = set_dist[i-1] + 1;
              set_key[i] = set_key[i-1];
              set_val[i] = set_val[i-1];
            end
            set_dist[pos] = home_d;
            set_key[pos] = w.key_hash;
            set_val[pos] = w.entry_value;
            set_count++;
          end
        end
      end
      MODE_REMOVE, MODE_LOOKUP: begin
        hit = probe_walk(w.key_hash, pos, home_d);
        if (!hit || !(set_dist[pos] < MAX_PROBE && set_key[pos] == w.key_hash)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.result_value = set_val[pos];
          if (w.mode == MODE_REMOVE) begin
            set_dist[pos] = MAX_PROBE;
            i = pos;
            while (i + 1 < SLOTS && set_dist[i+1] != 0 && set_dist[i+1] < MAX_PROBE) begin
              set_dist[i] = set_dist[i+1] - 1;
              set_key[i] = set_key[i+1];
              set_val[i] = set_val[i+1];
              set_dist[i+1] = MAX_PROBE;
              i++;
            end
            if (set_count > 0) set_count--;
          end
        end
      end
      default: clear_set();
    endcase
    r.entry_count = set_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_op(mode_t m, logic [31:0] k, logic [31:0] v);
    in_word_t w;
    w.mode = m;
    w.key_hash = k;
    w.entry_value = v;
    pending_ops.push_back(w);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) expected_answers.push_back(apply_op(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected word", 32'h0, 32'h0);
        end else begin
          want = expected_answers.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.found !== want.found)
            report_mismatch("found", out_data.found, want.found);
          if (out_data.result_value !== want.result_value)
            report_mismatch("result_value", out_data.result_value, want.result_value);
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", out_data.entry_count, want.entry_count);
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("** robin_hood_hash_set_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] k;
    int r;
    int n;
    clear_set();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, duplicates, a full home cluster, runs near the end.
    queue_op(MODE_LOOKUP, 32'h0, 32'h0);
    queue_op(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
    queue_op(MODE_INSERT, 32'h0, 32'hFFFF_FFFF);
    queue_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0);
    queue_op(MODE_INSERT, 32'h0, 32'h1234_5678);
    queue_op(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    for (int i = 1; i <= 7; i++) queue_op(MODE_INSERT, i * 64 + 63, 32'hA500_0000 + i);
    for (int i = 1; i <= 7; i++) queue_op(MODE_INSERT, i * 64 + 5, 32'h5A00_0000 + i);
    queue_op(MODE_LOOKUP, 32'h0000_0080, 32'h0);
    queue_op(MODE_REMOVE, 32'h0000_0045, 32'h0);
    queue_op(MODE_REMOVE, 32'h0000_007F, 32'h0);
    queue_op(MODE_LOOKUP, 32'h0000_013F, 32'h0);
    queue_op(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(MODE_LOOKUP, 32'h0, 32'h0);

    // Random phase: keys mostly drawn from 21 home slots, every third from 0 to 60, so that runs form.
    n = 0;
    while (n < 2000) begin
      r = $urandom_range(0, 99);
      if (r < 45 || live_keys.size() == 0) begin
        k = ($urandom_range(0, 15) == 0) ? $urandom()
            : ($urandom_range(0, 63) * 64 + $urandom_range(0, 20) * 3);
        if ($urandom_range(0, 1)) k = k ^ 32'h8000_0000;
        queue_op(MODE_INSERT, k, $urandom());
        if (live_keys.size() < 100) live_keys.push_back(k);
      end else if (r < 70) begin
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        queue_op(MODE_LOOKUP, k, $urandom());
      end else if (r < 93) begin
        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        queue_op(MODE_REMOVE, k, $urandom());
      end else if (r < 99) begin
        queue_op(($urandom_range(0, 1) ? MODE_LOOKUP : MODE_REMOVE), $urandom(), $urandom());
      end else begin
        queue_op(MODE_CLEAR, $urandom(), $urandom());
        live_keys.delete();
      end
      n++;
    end

    while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("** robin_hood_hash_set_core: PASSED **");
    end else begin
      $display("** robin_hood_hash_set_core: FAILED **");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/rhhs_pkg.sv
rtl/core/rhhs_ram.sv
rtl/core/robin_hood_hash_set_core.sv
tb/sv/tb_robin_hood_hash_set_core.sv
